[sv/ffvc_pkg.sv]
// Shared types and constants for the first-fit value clusterer.
package ffvc_pkg;

    localparam int GROUP_COUNT = 32;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_BITS    = 48;
    localparam int IDX_BITS    = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

    // One item moving down the chain of group cells.
    typedef struct packed {
        logic                  valid;
        logic                  placed;
        logic [VALUE_BITS-1:0] value;
        logic [IDX_BITS-1:0]   idx;
        logic [COUNT_BITS-1:0] count;
        logic [VALUE_BITS-1:0] min_val;
        logic [VALUE_BITS-1:0] max_val;
        logic [SUM_BITS-1:0]   sum;
    } token_t;

endpackage

[sv/ffvc_cell.sv]
// One group cell: holds a group's statistics and claims a passing item that fits.
module ffvc_cell
    import ffvc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [IDX_BITS-1:0] cell_idx,
    input  token_t              tok_in,
    output token_t              tok_out
);

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [VALUE_BITS-1:0] min_reg, min_next;
    logic [VALUE_BITS-1:0] max_reg, max_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic                  valid_reg;
    token_t                tok_reg, tok_next;

    logic [VALUE_BITS-1:0] t;
    logic [VALUE_BITS-1:0] diff_lo, diff_hi;
    logic [VALUE_BITS+1:0] triple_lo, triple_hi;
    logic [SUM_BITS:0]     sum_wide;
    logic                  fit_lo, fit_hi, fits, hit;

    always_comb begin
        t         = tok_in.value;
        diff_lo   = t - min_reg;
        diff_hi   = max_reg - t;
        triple_lo = {1'b0, diff_lo, 1'b0} + {2'b00, diff_lo};
        triple_hi = {1'b0, diff_hi, 1'b0} + {2'b00, diff_hi};
        fit_lo    = (min_reg <= t) && (triple_lo < {2'b00, min_reg});
        fit_hi    = (t <= max_reg) && (triple_hi < {2'b00, t});
        fits      = (count_reg == '0) || fit_lo || fit_hi;
        hit       = tok_in.valid && !tok_in.placed && fits;

        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        min_next   = (t < min_reg) ? t : min_reg;
        max_next   = (t > max_reg) ? t : max_reg;
        sum_wide   = {1'b0, sum_reg} + (SUM_BITS+1)'(t);
        sum_next   = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

        tok_next = tok_in;
        if (hit) begin
            tok_next.placed  = 1'b1;
            tok_next.idx     = cell_idx;
            tok_next.count   = count_next;
            tok_next.min_val = min_next;
            tok_next.max_val = max_next;
            tok_next.sum     = sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            sum_reg   <= '0;
        end else if (advance && hit) begin
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tok_reg <= tok_next;
        end
    end

    always_comb begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

[sv/first_fit_value_clusterer.sv]
// Top level of the first-fit value clusterer: a chain of group cells.
//
//  channel | direction | tdata (low bit up)                              | tuser
//  s_      | in        | timing_value[31:0]                              | -
//  m_      | out       | group_index, group_count, group_min,            | no_group
//          |           | group_max, group_sum, zero pad to 136 bits      |
//
// One item enters per cycle while the output is not stalled. Each item walks
// the chain one cell per cycle unless the chain is frozen. Its result is
// presented from the last cell's register once it has passed every cell. A
// following item trails one cell behind, so it sees every update of the one
// ahead.
// Reset clears all groups to empty at once; no clearing pass is needed.
// A stalled result at the output freezes the whole chain, holding s_tready low.
module first_fit_value_clusterer
    import ffvc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // timing_value[31:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // group_index[4:0], group_count[20:5], group_min[52:21],
    // group_max[84:53], group_sum[132:85], zero [135:133]
    output logic [135:0] m_tdata,
    output logic         m_tuser    // no_group
);

    token_t chain [GROUP_COUNT+1];
    logic   advance;
    logic [63:0] in_wide;
    logic [63:0] min_wide, max_wide;
    token_t last;

    // Advance the whole chain unless the finished result is still waiting.
    assign advance  = !chain[GROUP_COUNT].valid || m_tready;
    assign s_tready = advance;

    // Build a fresh, unplaced item from the input transaction.
    always_comb begin
        in_wide          = 64'(s_tdata);
        chain[0]         = '0;
        chain[0].valid   = s_tvalid;
        chain[0].value   = in_wide[VALUE_BITS-1:0];
    end

    for (genvar g = 0; g < GROUP_COUNT; g++) begin : g_cell
        localparam logic [31:0] IDX32 = 32'(g);
        ffvc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .cell_idx (IDX32[IDX_BITS-1:0]),
            .tok_in   (chain[g]),
            .tok_out  (chain[g+1])
        );
    end

    // The last cell's register is the output stage; an unplaced item reports no group.
    always_comb begin
        last     = chain[GROUP_COUNT];
        min_wide = 64'(last.min_val);
        max_wide = 64'(last.max_val);
        m_tvalid = last.valid;
        m_tuser  = !last.placed;
        if (last.placed) begin
            m_tdata = {3'b000, last.sum, max_wide[31:0], min_wide[31:0],
                       last.count, last.idx};
        end else begin
            m_tdata = '0;
        end
    end

    // A placed group is never empty.
    a_count_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[20:5] != 16'd0)
        else $error("placed result with zero member count");

    // A placed group's minimum never exceeds its maximum.
    a_min_le_max : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[52:21] <= m_tdata[84:53])
        else $error("group minimum above maximum");

    // A waiting result blocks new input.
    a_stall_blocks : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

endmodule

[test/first_fit_value_clusterer_tb.sv]
// Self-checking testbench for the first-fit value clusterer stream block.
`timescale 1ns / 1ps

module first_fit_value_clusterer_tb;
    import ffvc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = GROUP_COUNT + 8;
    localparam int RANDOM_ITEMS   = 480;
    localparam int REPEAT_ITEMS   = 90;

    // One expected placement as it should leave the m_ channel.
    typedef struct {
        logic [IDX_BITS-1:0]   group_index;
        logic                  no_group;
        logic [COUNT_BITS-1:0] group_count;
        logic [VALUE_BITS-1:0] group_min;
        logic [VALUE_BITS-1:0] group_max;
        logic [SUM_BITS-1:0]   group_sum;
    } placement_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tuser;

    // Group statistics as the predictor sees them.
    logic [COUNT_BITS-1:0] grp_count [GROUP_COUNT];
    logic [VALUE_BITS-1:0] grp_min   [GROUP_COUNT];
    logic [VALUE_BITS-1:0] grp_max   [GROUP_COUNT];
    logic [SUM_BITS-1:0]   grp_sum   [GROUP_COUNT];

    placement_t pending_placements[$];

    int mismatch_count = 0;
    int src_idle_max   = 9;
    int sink_idle_max  = 9;
    int sink_gap       = 0;
    int sink_hold      = 0;
    int stall_cycles   = 0;

    first_fit_value_clusterer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Empty groups take anything; otherwise the value must lie within a third
    // of the minimum above that minimum, or within a third of itself below the maximum.
    function automatic bit value_joins(int g, logic [VALUE_BITS-1:0] t);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] tv;
        lo = 64'(grp_min[g]);
        hi = 64'(grp_max[g]);
        tv = 64'(t);
        if (grp_count[g] == '0)
            return 1'b1;
        if (lo <= tv && 64'd3 * (tv - lo) < lo)
            return 1'b1;
        if (tv <= hi && 64'd3 * (hi - tv) < tv)
            return 1'b1;
        return 1'b0;
    endfunction

    // Place one value in the first group that takes it and return the result.
    function automatic placement_t place_timing(logic [VALUE_BITS-1:0] t);
        placement_t p;
        int         g;
        g = 0;
        while (g < GROUP_COUNT && !value_joins(g, t))
            g++;
        p = '{default: '0};
        if (g >= GROUP_COUNT) begin
            // Every group occupied and none fits: drop the value.
            p.no_group = 1'b1;
            return p;
        end
        if (grp_count[g] != COUNT_MAX)
            grp_count[g] = grp_count[g] + 1'b1;
        if (t < grp_min[g])
            grp_min[g] = t;
        if (t > grp_max[g])
            grp_max[g] = t;
        if (SUM_MAX - grp_sum[g] < {16'd0, t})
            grp_sum[g] = SUM_MAX;
        else
            grp_sum[g] = grp_sum[g] + {16'd0, t};
        p.group_index = g[IDX_BITS-1:0];
        p.group_count = grp_count[g];
        p.group_min   = grp_min[g];
        p.group_max   = grp_max[g];
        p.group_sum   = grp_sum[g];
        return p;
    endfunction

    // Mostly values aimed at an occupied group (some just past its reach),
    // plus zeros that open fresh groups and values spread over all magnitudes.
    function automatic logic [VALUE_BITS-1:0] draw_timing();
        int          pick;
        int          g;
        logic [63:0] base;
        logic [63:0] span;
        logic [63:0] delta;
        logic [63:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return '0;
        if (pick < 60) begin
            g = $urandom_range(0, GROUP_COUNT - 1);
            if (grp_count[g] != '0) begin
                if ($urandom_range(0, 1) == 0) begin
                    base  = 64'(grp_min[g]);
                    span  = base / 3;
                    delta = {32'd0, $urandom} % (span + span / 4 + 1);
                    v     = base + delta;
                    if (v > 64'hFFFF_FFFF)
                        v = 64'hFFFF_FFFF;
                end else begin
                    base  = 64'(grp_max[g]);
                    span  = base / 3;
                    delta = {32'd0, $urandom} % (span + span / 4 + 1);
                    v     = (delta > base) ? 64'd0 : base - delta;
                end
                return v[VALUE_BITS-1:0];
            end
        end
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one timing value after a random gap and record its placement
    // at the edge where the transaction completes.
    task automatic send_timing(input logic [VALUE_BITS-1:0] t);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_placements.push_back(place_timing(t));
    endtask

    // Drop tvalid and hold until every placement has come back, then let
    // the chain run dry.
    task automatic wait_for_results(input int extra);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_placements.size() == 0);
        repeat (extra) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Drive tready once per cycle: a long hold-off first, then the gap drawn
    // after the last result, otherwise ready.
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else begin
            m_tready <= aresetn;
        end
    end

    task automatic match_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result transaction with the oldest pending placement.
    always @(posedge aclk) begin : result_check
        placement_t want;
        if (aresetn && m_tvalid && m_tready) begin
            sink_gap <= $urandom_range(0, sink_idle_max);
            if (pending_placements.size() == 0) begin
                $error("result transaction with no placement pending");
                mismatch_count++;
            end else begin
                want = pending_placements.pop_front();
                match_field("group_index", 64'(want.group_index), 64'(m_tdata[4:0]));
                match_field("no_group",    64'(want.no_group),    64'(m_tuser));
                match_field("group_count", 64'(want.group_count), 64'(m_tdata[20:5]));
                match_field("group_min",   64'(want.group_min),   64'(m_tdata[52:21]));
                match_field("group_max",   64'(want.group_max),   64'(m_tdata[84:53]));
                match_field("group_sum",   64'(want.group_sum),   64'(m_tdata[132:85]));
            end
        end
    end

    // End the run when neither channel completes a transaction for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("first_fit_value_clusterer: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes, zero (which never joins an occupied group), and values right
    // on either side of the fit boundary below a maximum and above a minimum.
    task automatic test_directed();
        logic [VALUE_BITS-1:0] values[$];
        values = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'd300, 32'd399,
                   32'd400, 32'd1000, 32'd751, 32'd750, 32'hFFFF_FFFE, 32'd1,
                   32'd1, 32'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'hC000_0000, 32'hAAAA_AAAB, 32'h0000_FFFF};
        foreach (values[i])
            send_timing(values[i]);
        wait_for_results(DRAIN_CYCLES);
    endtask

    // Random values in phases with different idle patterns on both sides;
    // the groups fill up along the way, so dropped values show up later.
    task automatic test_random_mix();
        int src_caps[4]  = '{9, 0, 9, 0};
        int sink_caps[4] = '{9, 9, 0, 0};
        for (int phase = 0; phase < 4; phase++) begin
            src_idle_max  = src_caps[phase];
            sink_idle_max = sink_caps[phase];
            repeat (RANDOM_ITEMS / 4)
                send_timing(draw_timing());
        end
        src_idle_max  = 9;
        sink_idle_max = 9;
        wait_for_results(DRAIN_CYCLES);
    endtask

    // Hold the receiver off while items keep coming so the chain fills and
    // stalls its input; then pause the sender until everything is back.
    task automatic test_backpressure();
        src_idle_max = 0;
        @(posedge aclk);
        sink_hold = 300;
        repeat (80)
            send_timing(draw_timing());
        wait_for_results(0);
        src_idle_max = 9;
        repeat (20)
            send_timing(draw_timing());
        wait_for_results(DRAIN_CYCLES);
    endtask

    // Feed the largest value back to back so one group keeps growing its
    // count and total while every item trails the one ahead by a cell.
    task automatic test_repeat_max();
        src_idle_max  = 0;
        sink_idle_max = 0;
        repeat (REPEAT_ITEMS)
            send_timing('1);
        src_idle_max  = 9;
        sink_idle_max = 9;
        repeat (10)
            send_timing(draw_timing());
        wait_for_results(DRAIN_CYCLES);
    endtask

    initial begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
            grp_count[g] = '0;
            grp_min[g]   = '1;
            grp_max[g]   = '0;
            grp_sum[g]   = '0;
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_mix();
        test_backpressure();
        test_repeat_max();

        if (mismatch_count == 0 && pending_placements.size() == 0)
            $display("first_fit_value_clusterer: match");
        else
            $display("first_fit_value_clusterer: mismatch");
        $finish;
    end

endmodule
